// ===== rtl/gps_pkg.sv =====
// gps_pkg: shared types and constants of the gooch pixel shader
// used by every module of the block; depends on nothing else

package gps_pkg;

  localparam int NORM_IN_W  = 35;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 15;
  localparam int NORM_LAT   = 5 + SQRT_STEPS + DIV_STEPS + 1;
  localparam int BACK_TAIL  = 12;
  localparam int BACK_LAT   = 2 * NORM_LAT + BACK_TAIL;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [16:0] COOL_B  = 17'd36045;
  localparam logic [16:0] WARM_RG = 17'd39322;
  localparam logic [16:0] WARM_B  = 17'd6554;
  localparam logic [15:0] SPEC_K  = 16'd45875;

  localparam logic [2:0] REG_LIGHT_X  = 3'd0;
  localparam logic [2:0] REG_LIGHT_Y  = 3'd1;
  localparam logic [2:0] REG_LIGHT_Z  = 3'd2;
  localparam logic [2:0] REG_CAMERA_X = 3'd3;
  localparam logic [2:0] REG_CAMERA_Y = 3'd4;
  localparam logic [2:0] REG_CAMERA_Z = 3'd5;
  localparam logic [2:0] REG_BASE     = 3'd6;

  typedef struct packed {
    logic [15:0] light_x;
    logic [15:0] light_y;
    logic [15:0] light_z;
    logic [31:0] camera_x;
    logic [31:0] camera_y;
    logic [31:0] camera_z;
    logic [23:0] base_color;
  } cfg_t;

  typedef struct packed {
    logic [2:0][15:0] n;
    logic [2:0][16:0] l;
    logic [2:0][32:0] v;
  } raw_item_t;

  typedef struct packed {
    logic [2:0][29:0] mag;
    logic [2:0]       neg;
    logic             zero;
  } norm_side_t;

endpackage

// ===== rtl/gps_norm.sv =====
// gps_norm: pipelined vector normalizer, scale, pipelined isqrt, pipelined divide
// depends on gps_pkg

module gps_norm (
  input  logic                                 clk,
  input  logic [2:0][gps_pkg::NORM_IN_W-1:0]   vec_i,
  output logic [2:0][15:0]                     vec_o
);

  logic [2:0][34:0] mag_a_nxt;
  logic [2:0]       neg_a_nxt;
  logic [34:0]      max_a_nxt;
  logic [2:0][34:0] mag_a_r;
  logic [2:0]       neg_a_r;
  logic [34:0]      max_a_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_a_nxt[i] = vec_i[i][34];
      mag_a_nxt[i] = vec_i[i][34] ? 35'(-vec_i[i]) : vec_i[i];
    end
    max_a_nxt = mag_a_nxt[0];
    if (mag_a_nxt[1] > max_a_nxt) max_a_nxt = mag_a_nxt[1];
    if (mag_a_nxt[2] > max_a_nxt) max_a_nxt = mag_a_nxt[2];
  end

  always_ff @(posedge clk) begin
    mag_a_r <= mag_a_nxt;
    neg_a_r <= neg_a_nxt;
    max_a_r <= max_a_nxt;
  end

  // msb position of the largest magnitude
  logic [5:0]       pos_b_nxt;
  logic [5:0]       pos_b_r;
  logic [2:0][34:0] mag_b_r;
  logic [2:0]       neg_b_r;
  logic             zero_b_r;

  always_comb begin
    pos_b_nxt = '0;
    for (int k = 0; k < 35; k++) begin
      if (max_a_r[k]) pos_b_nxt = 6'(k);
    end
  end

  always_ff @(posedge clk) begin
    pos_b_r  <= pos_b_nxt;
    mag_b_r  <= mag_a_r;
    neg_b_r  <= neg_a_r;
    zero_b_r <= (max_a_r == '0);
  end

  // scale so the largest lies in [2^29, 2^30)
  gps_pkg::norm_side_t side_c_nxt;
  gps_pkg::norm_side_t side_c_r;

  always_comb begin
    logic [63:0] wide;
    wide = '0;
    for (int i = 0; i < 3; i++) begin
      wide = {29'b0, mag_b_r[i]};
      if (pos_b_r >= 6'd29) wide = wide >> (pos_b_r - 6'd29);
      else wide = wide << (6'd29 - pos_b_r);
      side_c_nxt.mag[i] = wide[29:0];
    end
    side_c_nxt.neg  = neg_b_r;
    side_c_nxt.zero = zero_b_r;
  end

  always_ff @(posedge clk) begin
    side_c_r <= side_c_nxt;
  end

  logic [2:0][59:0]    sq_d_r;
  gps_pkg::norm_side_t side_d_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq_d_r[i] <= 60'(side_c_r.mag[i]) * 60'(side_c_r.mag[i]);
    end
    side_d_r <= side_c_r;
  end

  // isqrt, one result bit per stage
  logic [63:0]         sx_r    [gps_pkg::SQRT_STEPS+1];
  logic [63:0]         sr_r    [gps_pkg::SQRT_STEPS+1];
  gps_pkg::norm_side_t sside_r [gps_pkg::SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    sx_r[0]    <= 64'(sq_d_r[0]) + 64'(sq_d_r[1]) + 64'(sq_d_r[2]);
    sr_r[0]    <= '0;
    sside_r[0] <= side_d_r;
  end

  for (genvar g = 0; g < gps_pkg::SQRT_STEPS; g++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'(1) << (62 - 2 * g);
    logic [63:0] trial;
    assign trial = sr_r[g] + BIT;
    always_ff @(posedge clk) begin
      if (sx_r[g] >= trial) begin
        sx_r[g+1] <= sx_r[g] - trial;
        sr_r[g+1] <= (sr_r[g] >> 1) + BIT;
      end else begin
        sx_r[g+1] <= sx_r[g];
        sr_r[g+1] <= sr_r[g] >> 1;
      end
      sside_r[g+1] <= sside_r[g];
    end
  end

  // restoring divide of mag*2^14 by the length, one quotient bit per stage
  logic [2:0][31:0]    drem_r  [1:gps_pkg::DIV_STEPS];
  logic [2:0][14:0]    dquo_r  [1:gps_pkg::DIV_STEPS];
  logic [30:0]         dlen_r  [1:gps_pkg::DIV_STEPS];
  gps_pkg::norm_side_t dside_r [1:gps_pkg::DIV_STEPS];

  for (genvar j = 0; j < gps_pkg::DIV_STEPS; j++) begin : g_div
    logic [2:0][31:0]    rem_in;
    logic [2:0][14:0]    quo_in;
    logic [30:0]         len_in;
    gps_pkg::norm_side_t side_in;
    logic [2:0][31:0]    cand;

    if (j == 0) begin : g_first
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          rem_in[i] = {2'b0, sside_r[gps_pkg::SQRT_STEPS].mag[i]};
          cand[i]   = rem_in[i];
        end
        quo_in  = '0;
        len_in  = sr_r[gps_pkg::SQRT_STEPS][30:0];
        side_in = sside_r[gps_pkg::SQRT_STEPS];
      end
    end else begin : g_rest
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          rem_in[i] = drem_r[j][i];
          cand[i]   = {rem_in[i][30:0], 1'b0};
        end
        quo_in  = dquo_r[j];
        len_in  = dlen_r[j];
        side_in = dside_r[j];
      end
    end

    always_ff @(posedge clk) begin
      for (int i = 0; i < 3; i++) begin
        if (cand[i] >= {1'b0, len_in}) begin
          drem_r[j+1][i] <= cand[i] - {1'b0, len_in};
          dquo_r[j+1][i] <= {quo_in[i][13:0], 1'b1};
        end else begin
          drem_r[j+1][i] <= cand[i];
          dquo_r[j+1][i] <= {quo_in[i][13:0], 1'b0};
        end
      end
      dlen_r[j+1]  <= len_in;
      dside_r[j+1] <= side_in;
    end
  end

  logic [2:0][15:0] vec_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (dside_r[gps_pkg::DIV_STEPS].zero) vec_r[i] <= '0;
      else if (dside_r[gps_pkg::DIV_STEPS].neg[i])
        vec_r[i] <= -{1'b0, dquo_r[gps_pkg::DIV_STEPS][i]};
      else vec_r[i] <= {1'b0, dquo_r[gps_pkg::DIV_STEPS][i]};
    end
  end

  assign vec_o = vec_r;

endmodule

// ===== rtl/gps_front.sv =====
// gps_front: accepts items and forms the raw normal, light and view vectors
// depends on gps_pkg

module gps_front (
  input  logic               start,
  input  logic               queue_full,
  input  logic [15:0]        normal_x,
  input  logic [15:0]        normal_y,
  input  logic [15:0]        normal_z,
  input  logic [31:0]        world_x,
  input  logic [31:0]        world_y,
  input  logic [31:0]        world_z,
  input  gps_pkg::cfg_t      cfg,
  output logic               busy,
  output logic               push,
  output gps_pkg::raw_item_t raw
);

  assign busy = queue_full;
  assign push = start && !queue_full;

  always_comb begin
    raw.n[0] = normal_x;
    raw.n[1] = normal_y;
    raw.n[2] = normal_z;
    // negated light direction
    raw.l[0] = -{cfg.light_x[15], cfg.light_x};
    raw.l[1] = -{cfg.light_y[15], cfg.light_y};
    raw.l[2] = -{cfg.light_z[15], cfg.light_z};
    // camera minus pixel position
    raw.v[0] = {cfg.camera_x[31], cfg.camera_x} - {world_x[31], world_x};
    raw.v[1] = {cfg.camera_y[31], cfg.camera_y} - {world_y[31], world_y};
    raw.v[2] = {cfg.camera_z[31], cfg.camera_z} - {world_z[31], world_z};
  end

endmodule

// ===== rtl/gps_fifo.sv =====
// gps_fifo: short item queue between front and back
// depends on gps_pkg

module gps_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  gps_pkg::raw_item_t wdata,
  input  logic               pop,
  output logic               full,
  output logic               not_empty,
  output gps_pkg::raw_item_t rdata
);

  gps_pkg::raw_item_t           mem [gps_pkg::FIFO_DEPTH];
  logic [gps_pkg::FIFO_AW-1:0]  wr_ptr_r;
  logic [gps_pkg::FIFO_AW-1:0]  rd_ptr_r;
  logic [gps_pkg::FIFO_AW:0]    count_r;
  logic                         do_pop;

  assign full      = (count_r == (gps_pkg::FIFO_AW+1)'(gps_pkg::FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_pop    = pop && not_empty;
  assign rdata     = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !do_pop) count_r <= count_r + 1'b1;
      else if (!push && do_pop) count_r <= count_r - 1'b1;
    end
  end

endmodule

// ===== rtl/gps_back.sv =====
// gps_back: shading pipeline, normalizers, dots, gooch blend, highlight, output
// depends on gps_pkg and gps_norm

module gps_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  gps_pkg::raw_item_t raw,
  input  logic [23:0]        base_color,
  output logic               out_valid,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue
);

  localparam int NL = gps_pkg::NORM_LAT;
  localparam int BL = gps_pkg::BACK_LAT;

  logic [BL-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[BL-2:0], in_vld};
  end

  assign out_valid = vld_r[BL-1];

  logic [2:0][34:0] n_in, l_in, v_in, h_in;
  logic [2:0][15:0] n_o, l_o, v_o, h_o;

  always_comb begin
    logic [16:0] h_sum;
    h_sum = '0;
    for (int i = 0; i < 3; i++) begin
      n_in[i] = {{19{raw.n[i][15]}}, raw.n[i]};
      l_in[i] = {{18{raw.l[i][16]}}, raw.l[i]};
      v_in[i] = {{2{raw.v[i][32]}}, raw.v[i]};
      h_sum   = {l_o[i][15], l_o[i]} + {v_o[i][15], v_o[i]};
      h_in[i] = {{18{h_sum[16]}}, h_sum};
    end
  end

  gps_norm u_norm_n (.clk(clk), .vec_i(n_in), .vec_o(n_o));
  gps_norm u_norm_l (.clk(clk), .vec_i(l_in), .vec_o(l_o));
  gps_norm u_norm_v (.clk(clk), .vec_i(v_in), .vec_o(v_o));
  gps_norm u_norm_h (.clk(clk), .vec_i(h_in), .vec_o(h_o));

  // n and l wait for the half vector
  logic [2:0][15:0] dn_r [NL];
  logic [2:0][15:0] dl_r [NL];

  always_ff @(posedge clk) begin
    dn_r[0] <= n_o;
    dl_r[0] <= l_o;
    for (int k = 1; k < NL; k++) begin
      dn_r[k] <= dn_r[k-1];
      dl_r[k] <= dl_r[k-1];
    end
  end

  logic signed [2:0][31:0] pnl_r, pnh_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pnl_r[i] <= $signed(dn_r[NL-1][i]) * $signed(dl_r[NL-1][i]);
      pnh_r[i] <= $signed(dn_r[NL-1][i]) * $signed(h_o[i]);
    end
  end

  logic signed [33:0] dnl_r, dnh_r;

  always_ff @(posedge clk) begin
    dnl_r <= 34'($signed(pnl_r[0])) + 34'($signed(pnl_r[1])) + 34'($signed(pnl_r[2]));
    dnh_r <= 34'($signed(pnh_r[0])) + 34'($signed(pnh_r[1])) + 34'($signed(pnh_r[2]));
  end

  logic signed [34:0] u_val;
  logic [21:0]        t_wide, s_wide;
  logic [16:0]        t_nxt, s_nxt;
  logic [16:0]        t_r [6];
  logic [16:0]        s_r [6];

  always_comb begin
    u_val  = 35'(dnl_r) + 35'sd268435456;
    t_wide = u_val[34] ? '0 : u_val[34:13];
    t_nxt  = (t_wide > 22'(gps_pkg::ONE_Q16)) ? gps_pkg::ONE_Q16 : t_wide[16:0];
    s_wide = (dnh_r > 0) ? dnh_r[33:12] : '0;
    s_nxt  = (s_wide > 22'(gps_pkg::ONE_Q16)) ? gps_pkg::ONE_Q16 : s_wide[16:0];
  end

  // five squarings
  always_ff @(posedge clk) begin
    t_r[0] <= t_nxt;
    s_r[0] <= s_nxt;
    for (int k = 1; k < 6; k++) begin
      t_r[k] <= t_r[k-1];
      s_r[k] <= 17'((34'(s_r[k-1]) * 34'(s_r[k-1])) >> 16);
    end
  end

  logic [16:0] hi_r, t9_r;

  always_ff @(posedge clk) begin
    hi_r <= 17'((33'(s_r[5]) * 33'(gps_pkg::SPEC_K)) >> 16);
    t9_r <= t_r[5];
  end

  logic [2:0][16:0] cool, warm;
  logic [2:0][33:0] pw_r, pc_r;
  logic [16:0]      hi10_r;

  always_comb begin
    logic [16:0] q;
    q = '0;
    for (int i = 0; i < 3; i++) begin
      q = 17'((17'(base_color[23-8*i -: 8]) * 17'd257) >> 2);
      cool[i] = (i == 2) ? q + gps_pkg::COOL_B : q;
      warm[i] = (i == 2) ? q + gps_pkg::WARM_B : q + gps_pkg::WARM_RG;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pw_r[i] <= 34'(t9_r) * 34'(warm[i]);
      pc_r[i] <= 34'(gps_pkg::ONE_Q16 - t9_r) * 34'(cool[i]);
    end
    hi10_r <= hi_r;
  end

  logic [2:0][16:0] val_r;

  always_ff @(posedge clk) begin
    logic [34:0] mix_sum;
    logic [19:0] vsum;
    for (int i = 0; i < 3; i++) begin
      mix_sum = 35'(pw_r[i]) + 35'(pc_r[i]);
      vsum    = 20'(mix_sum[34:16]) + 20'(hi10_r);
      val_r[i] <= (vsum > 20'(gps_pkg::ONE_Q16)) ? gps_pkg::ONE_Q16 : vsum[16:0];
    end
  end

  logic [2:0][7:0] rgb_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      rgb_r[i] <= 8'((25'(val_r[i]) * 25'd255) >> 16);
    end
  end

  assign out_red   = rgb_r[0];
  assign out_green = rgb_r[1];
  assign out_blue  = rgb_r[2];

endmodule

// ===== rtl/gooch_pixel_shader_top.sv =====
// gooch_pixel_shader_top: gooch shader with white blinn highlight, apb registers
// depends on gps_pkg, gps_front, gps_fifo, gps_back

// One item is taken every clock cycle while busy is low. Each item's result appears on the
// out_ ports after it is accepted, for one cycle, with out_valid high. The pipeline is built
// from four pipelined normalizers (bit-per-stage square root and divide, 53 stages
// each, two of them in series) plus twelve shading stages. The queue between
// front and back drains every cycle, so busy stays low in normal operation.

module gooch_pixel_shader_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_normal_x,
  input  logic [15:0] in_normal_y,
  input  logic [15:0] in_normal_z,
  input  logic [31:0] in_world_x,
  input  logic [31:0] in_world_y,
  input  logic [31:0] in_world_z,
  output logic        out_valid,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  gps_pkg::cfg_t      cfg_r;
  gps_pkg::raw_item_t raw, q_raw;
  logic               push, queue_full, q_vld;
  logic [2:0]         reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.light_x    <= 16'hD474;
      cfg_r.light_y    <= 16'hEE95;
      cfg_r.light_z    <= 16'h2B8C;
      cfg_r.camera_x   <= 32'h0000_0000;
      cfg_r.camera_y   <= 32'h0005_0000;
      cfg_r.camera_z   <= 32'hFFEC_0000;
      cfg_r.base_color <= 24'h3C68C8;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        gps_pkg::REG_LIGHT_X:  cfg_r.light_x    <= pwdata[15:0];
        gps_pkg::REG_LIGHT_Y:  cfg_r.light_y    <= pwdata[15:0];
        gps_pkg::REG_LIGHT_Z:  cfg_r.light_z    <= pwdata[15:0];
        gps_pkg::REG_CAMERA_X: cfg_r.camera_x   <= pwdata;
        gps_pkg::REG_CAMERA_Y: cfg_r.camera_y   <= pwdata;
        gps_pkg::REG_CAMERA_Z: cfg_r.camera_z   <= pwdata;
        gps_pkg::REG_BASE:     cfg_r.base_color <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      gps_pkg::REG_LIGHT_X:  prdata = {16'b0, cfg_r.light_x};
      gps_pkg::REG_LIGHT_Y:  prdata = {16'b0, cfg_r.light_y};
      gps_pkg::REG_LIGHT_Z:  prdata = {16'b0, cfg_r.light_z};
      gps_pkg::REG_CAMERA_X: prdata = cfg_r.camera_x;
      gps_pkg::REG_CAMERA_Y: prdata = cfg_r.camera_y;
      gps_pkg::REG_CAMERA_Z: prdata = cfg_r.camera_z;
      gps_pkg::REG_BASE:     prdata = {8'b0, cfg_r.base_color};
      default:               prdata = '0;
    endcase
  end

  gps_front u_front (
    .start      (start),
    .queue_full (queue_full),
    .normal_x   (in_normal_x),
    .normal_y   (in_normal_y),
    .normal_z   (in_normal_z),
    .world_x    (in_world_x),
    .world_y    (in_world_y),
    .world_z    (in_world_z),
    .cfg        (cfg_r),
    .busy       (busy),
    .push       (push),
    .raw        (raw)
  );

  gps_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wdata     (raw),
    .pop       (1'b1),
    .full      (queue_full),
    .not_empty (q_vld),
    .rdata     (q_raw)
  );

  gps_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (q_vld),
    .raw        (q_raw),
    .base_color (cfg_r.base_color),
    .out_valid  (out_valid),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue)
  );

endmodule

// ===== bench/gooch_shade_checker.sv =====
// gooch_shade_checker: watches the shader's item, result and register ports,
// predicts each pixel's color and compares it; depends on gps_pkg register indexes

module gooch_shade_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [15:0] in_normal_x,
  input  logic [15:0] in_normal_y,
  input  logic [15:0] in_normal_z,
  input  logic [31:0] in_world_x,
  input  logic [31:0] in_world_y,
  input  logic [31:0] in_world_z,
  input  logic        out_valid,
  input  logic [7:0]  out_red,
  input  logic [7:0]  out_green,
  input  logic [7:0]  out_blue,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          pending
);

  typedef struct {
    longint x;
    longint y;
    longint z;
  } vec3_t;

  localparam longint unsigned UNIT = 65536;

  logic [15:0] lit_x, lit_y, lit_z;
  logic [31:0] cam_x, cam_y, cam_z;
  logic [23:0] base_rgb;
  logic [23:0] color_q[$];

  function automatic longint unsigned int_sqrt(input longint unsigned a);
    longint unsigned r, b, x;
    r = 0;
    x = a;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unit_part(input longint unsigned mag, input longint unsigned len,
                                       input bit neg);
    longint q;
    q = longint'((mag << 14) / len);
    return neg ? -q : q;
  endfunction

  function automatic vec3_t unit_vec(input vec3_t v);
    longint unsigned mx, my, mz, m, sum, len;
    vec3_t o;
    mx = v.x < 0 ? -v.x : v.x;
    my = v.y < 0 ? -v.y : v.y;
    mz = v.z < 0 ? -v.z : v.z;
    m = mx;
    if (my > m) m = my;
    if (mz > m) m = mz;
    if (m == 0) begin
      o.x = 0; o.y = 0; o.z = 0;
      return o;
    end
    while (m >= (64'd1 << 30)) begin
      m = m >> 1; mx = mx >> 1; my = my >> 1; mz = mz >> 1;
    end
    while (m < (64'd1 << 29)) begin
      m = m << 1; mx = mx << 1; my = my << 1; mz = mz << 1;
    end
    sum = mx * mx + my * my + mz * mz;
    len = int_sqrt(sum);
    o.x = unit_part(mx, len, v.x < 0);
    o.y = unit_part(my, len, v.y < 0);
    o.z = unit_part(mz, len, v.z < 0);
    return o;
  endfunction

  function automatic longint dot(input vec3_t a, input vec3_t b);
    return a.x * b.x + a.y * b.y + a.z * b.z;
  endfunction

  function automatic logic [23:0] shade_pixel(input logic [15:0] nx, ny, nz,
                                              input logic [31:0] wx, wy, wz);
    vec3_t nr, lr, vr, hr, n, l, v, h;
    longint u, d;
    longint unsigned t, s, hi, b, q, cool, warm, val;
    logic [23:0] rgb;
    nr.x = longint'($signed(nx));
    nr.y = longint'($signed(ny));
    nr.z = longint'($signed(nz));
    lr.x = -longint'($signed(lit_x));
    lr.y = -longint'($signed(lit_y));
    lr.z = -longint'($signed(lit_z));
    vr.x = longint'($signed(cam_x)) - longint'($signed(wx));
    vr.y = longint'($signed(cam_y)) - longint'($signed(wy));
    vr.z = longint'($signed(cam_z)) - longint'($signed(wz));
    n = unit_vec(nr);
    l = unit_vec(lr);
    v = unit_vec(vr);
    hr.x = l.x + v.x;
    hr.y = l.y + v.y;
    hr.z = l.z + v.z;
    h = unit_vec(hr);
    u = dot(n, l) + (longint'(1) << 28);
    if (u < 0) u = 0;
    t = longint'(u) >> 13;
    if (t > UNIT) t = UNIT;
    d = dot(n, h);
    s = d > 0 ? (longint'(d) >> 12) : 0;
    if (s > UNIT) s = UNIT;
    for (int i = 0; i < 5; i++) s = (s * s) >> 16;
    hi = (s * 45875) >> 16;
    for (int i = 0; i < 3; i++) begin
      b = (base_rgb >> (16 - 8 * i)) & 8'hff;
      q = (b * 257) >> 2;
      cool = q + (i == 2 ? 36045 : 0);
      warm = q + (i == 2 ? 6554 : 39322);
      val = ((t * warm + (UNIT - t) * cool) >> 16) + hi;
      if (val > UNIT) val = UNIT;
      rgb[23 - 8 * i -: 8] = 8'((val * 255) >> 16);
    end
    return rgb;
  endfunction

  assign pending = color_q.size();

  always @(posedge clk) begin
    logic [23:0] want;
    if (!rst_n) begin
      lit_x <= 16'hd474;
      lit_y <= 16'hee95;
      lit_z <= 16'd11148;
      cam_x <= 32'd0;
      cam_y <= 32'd327680;
      cam_z <= 32'hffec0000;
      base_rgb <= 24'd3958984;
      color_q.delete();
      mismatches <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          gps_pkg::REG_LIGHT_X:  lit_x <= pwdata[15:0];
          gps_pkg::REG_LIGHT_Y:  lit_y <= pwdata[15:0];
          gps_pkg::REG_LIGHT_Z:  lit_z <= pwdata[15:0];
          gps_pkg::REG_CAMERA_X: cam_x <= pwdata;
          gps_pkg::REG_CAMERA_Y: cam_y <= pwdata;
          gps_pkg::REG_CAMERA_Z: cam_z <= pwdata;
          gps_pkg::REG_BASE:     base_rgb <= pwdata[23:0];
          default: ;
        endcase
      end
      if (out_valid) begin
        if (color_q.size() == 0) begin
          if (mismatches < 10) $display("unexpected result %h%h%h", out_red, out_green, out_blue);
          mismatches <= mismatches + 1;
        end else begin
          want = color_q.pop_front();
          if (want != {out_red, out_green, out_blue}) begin
            if (mismatches < 10)
              $display("color mismatch: expected r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                       want[23:16], want[15:8], want[7:0], out_red, out_green, out_blue);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (start && !busy)
        color_q = {color_q, shade_pixel(in_normal_x, in_normal_y, in_normal_z,
                                        in_world_x, in_world_y, in_world_z)};
    end
  end

endmodule

// ===== bench/gooch_pixel_shader_top_test.sv =====
// gooch_pixel_shader_top_test: drives pixels and register writes into the shader
// depends on gps_pkg, gooch_pixel_shader_top and gooch_shade_checker

module gooch_pixel_shader_top_test;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [15:0] in_normal_x, in_normal_y, in_normal_z;
  logic [31:0] in_world_x, in_world_y, in_world_z;
  logic        out_valid;
  logic [7:0]  out_red, out_green, out_blue;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          mismatches;
  int          pending;
  logic [31:0] shadow[0:6];
  int          idle_pct;

  gooch_pixel_shader_top uut (.*);
  gooch_shade_checker chk (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    if (idx < 7) shadow[idx] = val;
  endtask

  task automatic drain();
    start <= 0;
    while (pending != 0) @(posedge clk);
    repeat (gps_pkg::BACK_LAT + 10) @(posedge clk);
  endtask

  task automatic send_pixel(input logic [15:0] nx, ny, nz, input logic [31:0] wx, wy, wz);
    logic held;
    start <= 1;
    in_normal_x <= nx;
    in_normal_y <= ny;
    in_normal_z <= nz;
    in_world_x <= wx;
    in_world_y <= wy;
    in_world_z <= wz;
    do begin
      @(negedge clk);
      held = busy;
      @(posedge clk);
    end while (held);
    if ($urandom_range(99) < idle_pct) begin
      start <= 0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] sx16(input logic [31:0] v);
    return {{16{v[15]}}, v[15:0]};
  endfunction

  task automatic random_pixel();
    logic [15:0] n[3];
    logic [31:0] w[3];
    int k, mode;
    mode = $urandom_range(9);
    k = $urandom_range(64, 1);
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(3))
        0: n[i] = 16'($urandom);
        1: n[i] = 16'($urandom_range(32767, 0) - 16384);
        2: n[i] = 16'($urandom_range(200) - 100);
        default: n[i] = 16'(-shadow[i][15:0] + $urandom_range(4000) - 2000);
      endcase
      case (mode)
        0, 1: w[i] = $urandom;
        2: w[i] = shadow[3 + i];
        3: w[i] = shadow[3 + i] - sx16(shadow[i]) * k;
        4: w[i] = shadow[3 + i] + sx16(shadow[i]) * k;
        default: w[i] = shadow[3 + i] + $urandom_range(2000000) - 1000000;
      endcase
    end
    if ($urandom_range(30) == 0) n = '{16'd0, 16'd0, 16'd0};
    send_pixel(n[0], n[1], n[2], w[0], w[1], w[2]);
  endtask

  initial begin
    logic [31:0] l0, l1, l2, c0, c1, c2;
    rst_n = 0;
    start = 0;
    {in_normal_x, in_normal_y, in_normal_z} = '0;
    {in_world_x, in_world_y, in_world_z} = '0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    idle_pct = 0;
    shadow = '{32'hffffd474, 32'hffffee95, 32'd11148, 32'd0, 32'd327680, 32'hffec0000,
               32'd3958984};
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    l0 = sx16(shadow[0]); l1 = sx16(shadow[1]); l2 = sx16(shadow[2]);
    c0 = shadow[3]; c1 = shadow[4]; c2 = shadow[5];
    send_pixel(16'd0, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0);
    send_pixel(16'h7fff, 16'h7fff, 16'h7fff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_pixel(16'h8000, 16'h8000, 16'h8000, 32'h80000000, 32'h80000000, 32'h80000000);
    send_pixel(16'h8000, 16'h7fff, 16'h0001, 32'h80000000, 32'h7fffffff, 32'd1);
    send_pixel(16'd16384, 16'd0, 16'd0, c0, c1, c2);
    send_pixel(-l0[15:0], -l1[15:0], -l2[15:0], c0 - l0 * 4, c1 - l1 * 4, c2 - l2 * 4);
    send_pixel(-l0[15:0], -l1[15:0], -l2[15:0], c0 + l0 * 4, c1 + l1 * 4, c2 + l2 * 4);
    send_pixel(l0[15:0], l1[15:0], l2[15:0], 32'd0, 32'd0, 32'd0);
    send_pixel(16'hffff, 16'd1, 16'd0, 32'hffffffff, 32'd1, 32'd0);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: begin
          write_reg(gps_pkg::REG_LIGHT_X, 32'h8000);
          write_reg(gps_pkg::REG_LIGHT_Y, 32'h8000);
          write_reg(gps_pkg::REG_LIGHT_Z, 32'h8000);
          write_reg(gps_pkg::REG_CAMERA_X, 32'h7fffffff);
          write_reg(gps_pkg::REG_CAMERA_Y, 32'h80000000);
          write_reg(gps_pkg::REG_CAMERA_Z, 32'h7fffffff);
          write_reg(gps_pkg::REG_BASE, 32'hffffff);
          write_reg(3'(gps_pkg::REG_BASE + 3'd1), 32'hffffffff);
        end
        2: begin
          write_reg(gps_pkg::REG_LIGHT_X, 32'h7fff);
          write_reg(gps_pkg::REG_LIGHT_Y, 32'h7fff);
          write_reg(gps_pkg::REG_LIGHT_Z, 32'h7fff);
          write_reg(gps_pkg::REG_CAMERA_X, 32'h80000000);
          write_reg(gps_pkg::REG_CAMERA_Y, 32'h7fffffff);
          write_reg(gps_pkg::REG_CAMERA_Z, 32'h80000000);
          write_reg(gps_pkg::REG_BASE, 32'h000000);
        end
        3: begin
          write_reg(gps_pkg::REG_LIGHT_X, 32'd0);
          write_reg(gps_pkg::REG_LIGHT_Y, 32'd0);
          write_reg(gps_pkg::REG_LIGHT_Z, 32'd0);
          write_reg(gps_pkg::REG_BASE, $urandom);
        end
        4: for (int r = 0; r < 7; r++) write_reg(r[2:0], $urandom);
        default: ;
      endcase
      for (int j = 0; j < 268; j++) begin
        idle_pct = (j < 60) ? 0 : (j < 160 ? 83 : 19);
        if (j == 200) begin
          start <= 0;
          while (pending != 0) @(posedge clk);
        end
        random_pixel();
      end
      drain();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
